FILE: hw/rtl/srtt_pkg.sv
// Shared types, constants and helpers for the signed radix to text converter.
package srtt_pkg;

    localparam int MAX_RADIX   = 16;
    localparam int DIGIT_DEPTH = 32;
    localparam int DIGIT_AW    = $clog2(DIGIT_DEPTH);
    localparam int CNT_W       = DIGIT_AW + 1;
    localparam int RADIX_W     = 5;
    localparam int DIGIT_W     = 4;
    localparam int VALUE_W     = 32;
    localparam int CHAR_W      = 8;
    localparam int APB_DW      = 64;
    localparam int APB_AW      = 5;

    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

    // Register indexes, taken from paddr[4:3]
    typedef enum logic [1:0] {
        REG_RADIX   = 2'd0,
        REG_ALPH_LO = 2'd1,
        REG_ALPH_HI = 2'd2,
        REG_NONE    = 2'd3
    } reg_idx_t;

    // Alphabet: character i in element i
    typedef logic [MAX_RADIX-1:0][CHAR_W-1:0] alphabet_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_SIGN,
        ST_READ,
        ST_LOAD,
        ST_SEND_SIGN,
        ST_SEND_DIGIT
    } state_t;

    // Divider result bundle
    typedef struct packed {
        logic                 done;
        logic [VALUE_W-1:0]   quotient;
        logic [DIGIT_W-1:0]   remainder;
    } div_res_t;

    // Character for one digit
    function automatic logic [CHAR_W-1:0] alpha_char(input alphabet_t alph,
                                                     input logic [DIGIT_W-1:0] digit);
        return alph[digit];
    endfunction

endpackage

FILE: hw/rtl/srtt_alpha_check.sv
// Alphabet validity check: radix range, forbidden characters, duplicates.
module srtt_alpha_check
    import srtt_pkg::*;
(
    input  logic [RADIX_W-1:0] radix,
    input  alphabet_t          alph,
    output logic               ok
);

    logic bad_char;
    logic dup_char;
    logic range_ok;

    // Range of the radix
    assign range_ok = (radix >= RADIX_W'(2)) && (radix <= RADIX_W'(MAX_RADIX));

    // Forbidden characters among the ones in use
    always_comb begin
        bad_char = 1'b0;
        for (int i = 0; i < MAX_RADIX; i++) begin
            if ((RADIX_W'(i) < radix) &&
                ((alph[i] == '0) || (alph[i] == CH_PLUS) || (alph[i] == CH_MINUS))) begin
                bad_char = 1'b1;
            end
        end
    end

    // Pairwise duplicate search, all compares independent
    always_comb begin
        dup_char = 1'b0;
        for (int i = 0; i < MAX_RADIX; i++) begin
            for (int j = i + 1; j < MAX_RADIX; j++) begin
                if ((RADIX_W'(j) < radix) && (alph[i] == alph[j])) begin
                    dup_char = 1'b1;
                end
            end
        end
    end

    assign ok = range_ok && !bad_char && !dup_char;

endmodule

FILE: hw/rtl/srtt_divider.sv
// Restoring divider, one quotient bit per cycle, small divisor.
module srtt_divider
    import srtt_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [VALUE_W-1:0] dividend,
    input  logic [RADIX_W-1:0] divisor,
    output div_res_t           res
);

    localparam int STEP_W = $clog2(VALUE_W);

    logic [VALUE_W-1:0] quo_reg;
    logic [DIGIT_W-1:0] rem_reg;
    logic [RADIX_W-1:0] dvs_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               run_reg;
    logic               done_reg;

    logic [DIGIT_W:0]   trial;
    logic               fits;
    logic [DIGIT_W:0]   diff;

    // One shift-subtract step
    assign trial = {rem_reg, quo_reg[VALUE_W-1]};
    assign fits  = (trial >= dvs_reg);
    assign diff  = trial - dvs_reg;

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end else if (run_reg) begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(VALUE_W - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (run_reg) begin
            quo_reg <= {quo_reg[VALUE_W-2:0], fits};
            rem_reg <= fits ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
        end
    end

    assign res.done      = done_reg;
    assign res.quotient  = quo_reg;
    assign res.remainder = rem_reg;

endmodule

FILE: hw/rtl/signed_radix_to_text.sv
// Top level: signed value to text in a configured radix and alphabet.
//
//  channel   | dir | word
//  ----------+-----+----------------------------------------------
//  s_ (in)   | in  | tdata[31:0] value
//  m_ (out)  | out | tdata[7:0] character, tlast = last
//  APB       | in  | radix @0x00, alphabet_low @0x08, alphabet_high @0x10
//
// Each digit is one pass of the shared bit-serial divider, for up to
// 32 digits in base two. Each character then goes through a digit store
// read, an alphabet lookup and a send, plus any sink stall.
// s_tready is high only while idle. Reset is synchronous, active low, and
// clears control state and registers; the digit store needs no clearing.
module signed_radix_to_text
    import srtt_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,   // [31:0] value

    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [7:0] character
    output logic              m_tlast,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    // Configuration registers
    logic [RADIX_W-1:0] radix_reg;
    logic [APB_DW-1:0]  alph_lo_reg;
    logic [APB_DW-1:0]  alph_hi_reg;
    reg_idx_t           reg_idx;
    logic               cfg_wr;
    alphabet_t          alph;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[4:3]);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign alph    = alphabet_t'({alph_hi_reg, alph_lo_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg   <= '0;
            alph_lo_reg <= '0;
            alph_hi_reg <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_RADIX:   radix_reg   <= pwdata[RADIX_W-1:0];
                REG_ALPH_LO: alph_lo_reg <= pwdata;
                REG_ALPH_HI: alph_hi_reg <= pwdata;
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        unique case (reg_idx)
            REG_RADIX:   prdata = {{(APB_DW-RADIX_W){1'b0}}, radix_reg};
            REG_ALPH_LO: prdata = alph_lo_reg;
            REG_ALPH_HI: prdata = alph_hi_reg;
            default:     prdata = '0;
        endcase
    end

    // Alphabet check
    logic alph_ok;

    srtt_alpha_check u_check (
        .radix (radix_reg),
        .alph  (alph),
        .ok    (alph_ok)
    );

    // Sequencer state
    state_t             state_reg, state_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic               neg_reg, neg_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DIGIT_AW-1:0] k_reg, k_next;
    logic               mval_reg, mval_next;
    logic [CHAR_W-1:0]  mchar_reg, mchar_next;
    logic               mlast_reg, mlast_next;

    logic               div_start;
    logic [VALUE_W-1:0] div_dividend;
    div_res_t           div_res;
    logic               wr_en;
    logic               rd_en;
    logic [VALUE_W-1:0] mag;

    logic [DIGIT_W-1:0] digit_mem [DIGIT_DEPTH];
    logic [DIGIT_W-1:0] rd_data_reg;

    // Shared divider
    srtt_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (radix_reg),
        .res      (div_res)
    );

    // Unsigned magnitude, covers the minimum value
    assign mag = value_reg[VALUE_W-1] ? (VALUE_W'(0) - value_reg) : value_reg;

    // Next state and outputs
    always_comb begin
        state_next   = state_reg;
        value_next   = value_reg;
        neg_next     = neg_reg;
        cnt_next     = cnt_reg;
        k_next       = k_reg;
        mval_next    = mval_reg;
        mchar_next   = mchar_reg;
        mlast_next   = mlast_reg;
        div_start    = 1'b0;
        div_dividend = div_res.quotient;
        wr_en        = 1'b0;
        rd_en        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    value_next = s_tdata;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (alph_ok) begin
                    neg_next     = value_reg[VALUE_W-1];
                    cnt_next     = '0;
                    div_start    = 1'b1;
                    div_dividend = mag;
                    state_next   = ST_DIVIDE;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIVIDE: begin
                if (div_res.done) begin
                    wr_en    = 1'b1;
                    cnt_next = cnt_reg + CNT_W'(1);
                    if ((div_res.quotient == '0) ||
                        (cnt_reg == CNT_W'(DIGIT_DEPTH - 1))) begin
                        k_next     = cnt_reg[DIGIT_AW-1:0];
                        state_next = ST_SIGN;
                    end else begin
                        div_start = 1'b1;
                    end
                end
            end
            ST_SIGN: begin
                if (neg_reg) begin
                    mval_next  = 1'b1;
                    mchar_next = CH_MINUS;
                    mlast_next = 1'b0;
                    state_next = ST_SEND_SIGN;
                end else begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                rd_en      = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                mval_next  = 1'b1;
                mchar_next = alpha_char(alph, rd_data_reg);
                mlast_next = (k_reg == '0);
                state_next = ST_SEND_DIGIT;
            end
            ST_SEND_SIGN: begin
                if (m_tready) begin
                    mval_next  = 1'b0;
                    state_next = ST_READ;
                end
            end
            ST_SEND_DIGIT: begin
                if (m_tready) begin
                    mval_next = 1'b0;
                    if (k_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        k_next     = k_reg - DIGIT_AW'(1);
                        state_next = ST_READ;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            neg_reg   <= 1'b0;
            cnt_reg   <= '0;
            k_reg     <= '0;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            neg_reg   <= neg_next;
            cnt_reg   <= cnt_next;
            k_reg     <= k_next;
            mval_reg  <= mval_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        mchar_reg <= mchar_next;
        mlast_reg <= mlast_next;
    end

    // Digit store, least significant digit first
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            digit_mem[cnt_reg[DIGIT_AW-1:0]] <= div_res.remainder;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= digit_mem[k_reg];
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mval_reg;
    assign m_tdata  = mchar_reg;
    assign m_tlast  = mlast_reg;

`ifndef SYNTH
    // Digit count stays within the store
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(DIGIT_DEPTH))
        else $error("digit count beyond store depth");

    // Input and output sides never active together
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while a word is pending");

    // Last mark only on the least significant digit
    a_last_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (state_reg == ST_SEND_DIGIT) && (k_reg == '0))
        else $error("last mark on a non-final word");

    // Divider finishes only while the sequencer waits on it
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_res.done |-> (state_reg == ST_DIVIDE))
        else $error("divider done outside divide phase");

    // A digit pass begins only after a check
    a_div_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (div_start && (state_reg == ST_CHECK)) |-> alph_ok)
        else $error("conversion started with invalid alphabet");
`endif

endmodule
